[hdl/nat_port_translation_engine_defines.svh]
// ----------------------------------------------------------------------------
// nat port translation engine assertion macros
// shared assertion forms, clocked on clk_i and quiet while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef NAT_PORT_TRANSLATION_ENGINE_DEFINES_SVH
`define NAT_PORT_TRANSLATION_ENGINE_DEFINES_SVH

// property that holds at every clock edge
`define NPTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define NPTE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NPTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/npte_pkg.sv]
// ----------------------------------------------------------------------------
// npte_pkg
// shared types, constants and helpers of the nat port translation engine
// ----------------------------------------------------------------------------
package npte_pkg;

  // default table sizes
  localparam int unsigned SESSION_ENTRIES_DEF = 65536;
  localparam int unsigned SESSION_WAYS_DEF    = 4;
  localparam int unsigned REVERSE_ENTRIES_DEF = 65536;

  // hash multipliers
  localparam logic [31:0] HASH_K1 = 32'h9E3779B1;
  localparam logic [31:0] HASH_K2 = 32'h85EBCA6B;
  localparam logic [31:0] HASH_K3 = 32'h2C1B3C6D;

  // register reset values
  localparam logic [31:0] WAN_ADDR_RST   = 32'd0;
  localparam logic [15:0] FIRST_PORT_RST = 16'd10000;
  localparam logic [15:0] END_PORT_RST   = 16'd60000;

  // translated protocols
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [1:0] {
    ACT_PASS  = 2'd0,
    ACT_XLATE = 2'd1,
    ACT_DROP  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CFG_WAN_ADDR   = 2'd0,
    CFG_FIRST_PORT = 2'd1,
    CFG_END_PORT   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] wan;
    logic [7:0]  proto;
  } sess_entry_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  proto;
    logic [31:0] addr;
    logic [15:0] port;
  } rev_entry_t;

  // old and new header words for the checksum update
  typedef struct packed {
    logic [15:0] ipc;
    logic [15:0] l4c;
    logic [31:0] sa;
    logic [31:0] nsa;
    logic [31:0] da;
    logic [31:0] nda;
    logic [15:0] sp;
    logic [15:0] nsp;
    logic [15:0] dp;
    logic [15:0] ndp;
  } csum_in_t;

  typedef struct packed {
    logic [15:0] ip;
    logic [15:0] l4;
  } csum_out_t;

  // one end-around carry fold of an 18-bit sum
  function automatic logic [17:0] fold(input logic [17:0] s);
    fold = {2'b00, s[15:0]} + {16'd0, s[17:16]};
  endfunction

endpackage

[hdl/npte_hash.sv]
// ----------------------------------------------------------------------------
// npte_hash
// five-tuple mixing hash over one shared 32x32 multiplier
// ----------------------------------------------------------------------------
module npte_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] sa_i,
  input  logic [31:0] da_i,
  input  logic [15:0] sp_i,
  input  logic [15:0] dp_i,
  input  logic [7:0]  pr_i,
  output logic        done_o,
  output logic [31:0] hash_o
);

  typedef enum logic [2:0] {
    H_M1, H_M2, H_MIX, H_M3, H_FIN
  } hstep_e;

  hstep_e      step_q;
  logic        busy_q;
  logic        done_q;
  logic [31:0] p_q;
  logic [31:0] x_q;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] prod;
  logic [31:0] mix;
  logic [31:0] mix_sh;

  // multiplier operand select
  always_comb begin
    case (step_q)
      H_M1: begin
        op_a = sa_i;
        op_b = npte_pkg::HASH_K1;
      end
      H_M2: begin
        op_a = {sp_i, dp_i};
        op_b = npte_pkg::HASH_K2;
      end
      default: begin
        op_a = x_q;
        op_b = npte_pkg::HASH_K3;
      end
    endcase
  end

  assign prod   = op_a * op_b;
  assign mix    = x_q ^ p_q ^ {24'd0, pr_i};
  assign mix_sh = mix ^ (mix >> 15);

  // step sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= H_M1;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= H_M1;
      end else if (busy_q) begin
        case (step_q)
          H_M1: begin
            step_q <= H_M2;
          end
          H_M2: begin
            step_q <= H_MIX;
          end
          H_MIX: begin
            step_q <= H_M3;
          end
          H_M3: begin
            step_q <= H_FIN;
          end
          default: begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
            step_q <= H_M1;
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      case (step_q)
        H_M1: p_q <= prod;
        H_M2: begin
          x_q <= p_q ^ da_i;
          p_q <= prod;
        end
        H_MIX: x_q <= mix_sh;
        H_M3:  p_q <= prod;
        default: x_q <= p_q ^ (p_q >> 12);
      endcase
    end
  end

  assign done_o = done_q;
  assign hash_o = x_q;

endmodule

[hdl/npte_mod.sv]
// ----------------------------------------------------------------------------
// npte_mod
// remainder of a 32-bit value by the divisor input, reciprocal multiply over one
// shared 32x32 multiplier
// ----------------------------------------------------------------------------
module npte_mod #(
  parameter int unsigned MOD_W = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      dividend_i,
  input  logic [MOD_W-1:0] divisor_i,
  input  logic [31:0]      recip_i,
  output logic             done_o,
  output logic [MOD_W-1:0] rem_o
);

  typedef enum logic [1:0] {
    M_QUOT, M_PROD, M_FIX
  } mstep_e;

  mstep_e           step_q;
  logic             busy_q;
  logic             done_q;
  logic [31:0]      dvd_q;
  logic [31:0]      rec_q;
  logic [31:0]      quot_q;
  logic [31:0]      part_q;
  logic [MOD_W-1:0] div_q;
  logic [MOD_W-1:0] rem_q;
  logic [31:0]      div_w;
  logic [31:0]      op_a;
  logic [31:0]      op_b;
  logic [63:0]      prod;

  assign div_w = {{(32-MOD_W){1'b0}}, div_q};

  // multiplier operand select: estimate quotient, then quotient times divisor
  always_comb begin
    case (step_q)
      M_QUOT: begin
        op_a = dvd_q;
        op_b = rec_q;
      end
      default: begin
        op_a = quot_q;
        op_b = div_w;
      end
    endcase
  end

  assign prod = {32'd0, op_a} * {32'd0, op_b};

  // step sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= M_QUOT;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= M_QUOT;
      end else if (busy_q) begin
        case (step_q)
          M_QUOT: begin
            step_q <= M_PROD;
          end
          M_PROD: begin
            step_q <= M_FIX;
          end
          default: begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
            step_q <= M_QUOT;
          end
        endcase
      end
    end
  end

  // datapath: the estimate is at most one low, so one subtract corrects it
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rec_q <= recip_i;
    end else if (busy_q) begin
      case (step_q)
        M_QUOT: quot_q <= prod[63:32];
        M_PROD: part_q <= dvd_q - prod[31:0];
        default: rem_q <= (part_q >= div_w) ? MOD_W'(part_q - div_w) : part_q[MOD_W-1:0];
      endcase
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[hdl/npte_csum.sv]
// ----------------------------------------------------------------------------
// npte_csum
// incremental one's-complement checksum update, one word pair per cycle
// ----------------------------------------------------------------------------
module npte_csum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  npte_pkg::csum_in_t  csum_i,
  output logic                done_o,
  output npte_pkg::csum_out_t csum_o
);

  logic                busy_q;
  logic                done_q;
  logic [3:0]          step_q;
  logic [15:0]         acc_q;
  npte_pkg::csum_out_t res_q;
  logic [15:0]         old_w;
  logic [15:0]         new_w;
  logic [17:0]         sum;
  logic [17:0]         sum_f;

  // word pair for this step: ip header first, then the l4 pseudo header and ports
  always_comb begin
    case (step_q)
      4'd0, 4'd4: begin
        old_w = csum_i.sa[31:16];
        new_w = csum_i.nsa[31:16];
      end
      4'd1, 4'd5: begin
        old_w = csum_i.sa[15:0];
        new_w = csum_i.nsa[15:0];
      end
      4'd2, 4'd6: begin
        old_w = csum_i.da[31:16];
        new_w = csum_i.nda[31:16];
      end
      4'd3, 4'd7: begin
        old_w = csum_i.da[15:0];
        new_w = csum_i.nda[15:0];
      end
      4'd8: begin
        old_w = csum_i.sp;
        new_w = csum_i.nsp;
      end
      default: begin
        old_w = csum_i.dp;
        new_w = csum_i.ndp;
      end
    endcase
  end

  assign sum   = {2'b00, acc_q} + {2'b00, ~old_w} + {2'b00, new_w};
  assign sum_f = npte_pkg::fold(npte_pkg::fold(sum));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 4'd1;
        if (step_q == 4'd9) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // accumulator, switches to the l4 checksum after the ip words
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= ~csum_i.ipc;
    end else if (busy_q) begin
      if (step_q == 4'd3) begin
        res_q.ip <= ~sum_f[15:0];
        acc_q    <= ~csum_i.l4c;
      end else if (step_q == 4'd9) begin
        res_q.l4 <= ~sum_f[15:0];
      end else begin
        acc_q <= sum_f[15:0];
      end
    end
  end

  assign done_o = done_q;
  assign csum_o = res_q;

endmodule

[hdl/nat_port_translation_engine.sv]
// outbound items run the hash, the set remainder, the session read and check, then
//   for a new session the reverse remainder, and the checksum update; inbound items
//   to the wan address run the reverse remainder, read and check; others pass through
// one item at a time: in_ready_o is high only while idle, until the result is taken
// reset: a clearing pass over max(SESSION_ENTRIES/SESSION_WAYS, REVERSE_ENTRIES)
//   entries (65536 by default) runs first, with in_ready_o low
// ----------------------------------------------------------------------------
// nat_port_translation_engine
// source nat with port translation, session and reverse tables in block memory
// ----------------------------------------------------------------------------
module nat_port_translation_engine #(
  parameter int unsigned SESSION_ENTRIES = npte_pkg::SESSION_ENTRIES_DEF,
  parameter int unsigned SESSION_WAYS    = npte_pkg::SESSION_WAYS_DEF,
  parameter int unsigned REVERSE_ENTRIES = npte_pkg::REVERSE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic        is_ipv4_i,
  input  logic [7:0]  protocol_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] dest_address_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [15:0] ip_checksum_in_i,
  input  logic [15:0] l4_checksum_in_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  action_o,
  output logic [31:0] new_source_address_o,
  output logic [31:0] new_dest_address_o,
  output logic [15:0] new_source_port_o,
  output logic [15:0] new_dest_port_o,
  output logic [15:0] ip_checksum_out_o,
  output logic [15:0] l4_checksum_out_o
);

  localparam int unsigned SETS   = SESSION_ENTRIES / SESSION_WAYS;
  localparam int unsigned SET_W  = $clog2(SETS);
  localparam int unsigned REV_W  = $clog2(REVERSE_ENTRIES);
  localparam int unsigned MOD_W  = ((SET_W > REV_W) ? SET_W : REV_W) + 1;
  localparam int unsigned CLR_N  = (SETS > REVERSE_ENTRIES) ? SETS : REVERSE_ENTRIES;
  localparam int unsigned CLR_W  = $clog2(CLR_N);
  localparam int unsigned WAY_W  = (SESSION_WAYS > 1) ? $clog2(SESSION_WAYS) : 1;
  localparam logic [MOD_W-1:0] SETS_M = MOD_W'(SETS);
  localparam logic [MOD_W-1:0] REV_M  = MOD_W'(REVERSE_ENTRIES);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);
  // reciprocals for the remainder unit, floor(2^32 / divisor)
  localparam logic [31:0] SETS_R = 32'((64'd1 << 32) / 64'(SETS));
  localparam logic [31:0] REV_R  = 32'((64'd1 << 32) / 64'(REVERSE_ENTRIES));

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_MSET, ST_SRD, ST_SCHK,
    ST_MREV, ST_RRD, ST_RCHK, ST_CSUM, ST_OUT
  } state_e;

  typedef npte_pkg::sess_entry_t [SESSION_WAYS-1:0] sess_row_t;

  state_e              state_q;
  logic [CLR_W-1:0]    clr_q;
  logic [31:0]         wan_addr_q;
  logic [15:0]         end_port_q;
  logic [16:0]         next_port_q;

  // captured item
  logic                mode_q;
  logic [7:0]          pr_q;
  logic [31:0]         sa_q;
  logic [31:0]         da_q;
  logic [15:0]         sp_q;
  logic [15:0]         dp_q;
  logic [15:0]         ipc_q;
  logic [15:0]         l4c_q;

  // result registers
  npte_pkg::action_e   act_q;
  logic [31:0]         nsa_q;
  logic [31:0]         nda_q;
  logic [15:0]         nsp_q;
  logic [15:0]         ndp_q;
  logic [15:0]         nipc_q;
  logic [15:0]         nl4c_q;

  logic [SET_W-1:0]    set_idx_q;
  logic [REV_W-1:0]    rev_idx_q;
  logic                hash_start_q;
  logic                mod_start_q;
  logic                csum_start_q;
  logic [31:0]         mod_dvd_q;
  logic [MOD_W-1:0]    mod_div_q;
  logic [31:0]         mod_rec_q;

  // memories
  sess_row_t           sess_mem [SETS];
  npte_pkg::rev_entry_t rev_mem [REVERSE_ENTRIES];
  sess_row_t           sess_rd_q;
  npte_pkg::rev_entry_t rev_rd_q;
  logic                sess_we;
  logic [SET_W-1:0]    sess_wa;
  sess_row_t           sess_wd;
  logic                rev_we;
  logic [REV_W-1:0]    rev_wa;
  npte_pkg::rev_entry_t rev_wd;

  // unit handshakes
  logic                hash_done;
  logic [31:0]         hash_val;
  logic                mod_done;
  logic [MOD_W-1:0]    mod_rem;
  logic                csum_done;
  npte_pkg::csum_in_t  csum_in;
  npte_pkg::csum_out_t csum_out;

  logic                in_acc;
  logic                l4ok_in;
  logic                hit_any;
  logic                free_any;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic                port_ok;
  logic                insert;
  logic                clr_sess;
  logic                clr_rev;
  logic                l4_keep;
  logic [15:0]         l4_fix;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign l4ok_in    = is_ipv4_i &&
                      (protocol_i == npte_pkg::PROTO_TCP || protocol_i == npte_pkg::PROTO_UDP);

  // way search over the read set
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < SESSION_WAYS; w++) begin
      if (sess_rd_q[w].valid) begin
        if (!hit_any && sess_rd_q[w].src == sa_q && sess_rd_q[w].dst == da_q &&
            sess_rd_q[w].sport == sp_q && sess_rd_q[w].dport == dp_q &&
            sess_rd_q[w].proto == pr_q) begin
          hit_any = 1'b1;
          hit_way = WAY_W'(w);
        end
      end else if (!free_any) begin
        free_any = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  assign port_ok = next_port_q < {1'b0, end_port_q};
  assign insert  = (state_q == ST_SCHK) && !hit_any && free_any && port_ok;

  // clearing pass coverage of each table
  assign clr_sess = (state_q == ST_CLEAR) && ({{(32-CLR_W){1'b0}}, clr_q} < 32'(SETS));
  assign clr_rev  = (state_q == ST_CLEAR) &&
                    ({{(32-CLR_W){1'b0}}, clr_q} < 32'(REVERSE_ENTRIES));

  // session write: clear or insert into the free way
  always_comb begin
    sess_wd = sess_rd_q;
    for (int w = 0; w < SESSION_WAYS; w++) begin
      if (WAY_W'(w) == free_way) begin
        sess_wd[w].valid = 1'b1;
        sess_wd[w].src   = sa_q;
        sess_wd[w].dst   = da_q;
        sess_wd[w].sport = sp_q;
        sess_wd[w].dport = dp_q;
        sess_wd[w].proto = pr_q;
        sess_wd[w].wan   = next_port_q[15:0];
      end
    end
    if (state_q == ST_CLEAR) begin
      sess_wd = '0;
    end
  end

  assign sess_we = clr_sess || insert;
  assign sess_wa = (state_q == ST_CLEAR) ? clr_q[SET_W-1:0] : set_idx_q;

  // reverse write: clear or record the new wan port
  assign rev_we = clr_rev || ((state_q == ST_MREV) && mod_done && !mode_q);
  assign rev_wa = (state_q == ST_CLEAR) ? clr_q[REV_W-1:0] : mod_rem[REV_W-1:0];
  always_comb begin
    rev_wd.valid = 1'b1;
    rev_wd.proto = pr_q;
    rev_wd.addr  = sa_q;
    rev_wd.port  = sp_q;
    if (state_q == ST_CLEAR) begin
      rev_wd = '0;
    end
  end

  // session memory
  always_ff @(posedge clk_i) begin
    if (sess_we) begin
      sess_mem[sess_wa] <= sess_wd;
    end
    sess_rd_q <= sess_mem[set_idx_q];
  end

  // reverse memory
  always_ff @(posedge clk_i) begin
    if (rev_we) begin
      rev_mem[rev_wa] <= rev_wd;
    end
    rev_rd_q <= rev_mem[rev_idx_q];
  end

  // udp checksum rules
  assign l4_keep = (pr_q == npte_pkg::PROTO_UDP) && (l4c_q == 16'd0);
  assign l4_fix  = ((pr_q == npte_pkg::PROTO_UDP) && (csum_out.l4 == 16'd0)) ?
                   16'hFFFF : csum_out.l4;

  // sequencer, configuration and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      wan_addr_q   <= npte_pkg::WAN_ADDR_RST;
      end_port_q   <= npte_pkg::END_PORT_RST;
      next_port_q  <= {1'b0, npte_pkg::FIRST_PORT_RST};
      hash_start_q <= 1'b0;
      mod_start_q  <= 1'b0;
      csum_start_q <= 1'b0;
      act_q        <= npte_pkg::ACT_PASS;
    end else begin
      hash_start_q <= 1'b0;
      mod_start_q  <= 1'b0;
      csum_start_q <= 1'b0;

      // a first port write also restarts the port counter
      if (cfg_we_i) begin
        case (cfg_idx_i)
          npte_pkg::CFG_WAN_ADDR: wan_addr_q <= cfg_data_i;
          npte_pkg::CFG_FIRST_PORT: begin
            next_port_q <= {1'b0, cfg_data_i[15:0]};
          end
          npte_pkg::CFG_END_PORT: end_port_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + CLR_W'(1);
          if (clr_q == CLR_LAST) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            mode_q <= mode_i;
            pr_q   <= protocol_i;
            sa_q   <= source_address_i;
            da_q   <= dest_address_i;
            sp_q   <= source_port_i;
            dp_q   <= dest_port_i;
            ipc_q  <= ip_checksum_in_i;
            l4c_q  <= l4_checksum_in_i;
            nsa_q  <= source_address_i;
            nda_q  <= dest_address_i;
            nsp_q  <= source_port_i;
            ndp_q  <= dest_port_i;
            nipc_q <= ip_checksum_in_i;
            nl4c_q <= l4_checksum_in_i;
            act_q  <= npte_pkg::ACT_PASS;
            if (l4ok_in && !mode_i) begin
              hash_start_q <= 1'b1;
              state_q      <= ST_HASH;
            end else if (l4ok_in && dest_address_i == wan_addr_q) begin
              mod_start_q <= 1'b1;
              mod_dvd_q   <= {16'd0, dest_port_i};
              mod_div_q   <= REV_M;
              mod_rec_q   <= REV_R;
              state_q     <= ST_MREV;
            end else begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            mod_start_q <= 1'b1;
            mod_dvd_q   <= hash_val;
            mod_div_q   <= SETS_M;
            mod_rec_q   <= SETS_R;
            state_q     <= ST_MSET;
          end
        end
        ST_MSET: begin
          if (mod_done) begin
            set_idx_q <= mod_rem[SET_W-1:0];
            state_q   <= ST_SRD;
          end
        end
        ST_SRD: begin
          state_q <= ST_SCHK;
        end
        ST_SCHK: begin
          if (hit_any) begin
            act_q        <= npte_pkg::ACT_XLATE;
            nsa_q        <= wan_addr_q;
            nsp_q        <= sess_rd_q[hit_way].wan;
            csum_start_q <= 1'b1;
            state_q      <= ST_CSUM;
          end else if (insert) begin
            act_q       <= npte_pkg::ACT_XLATE;
            nsa_q       <= wan_addr_q;
            nsp_q       <= next_port_q[15:0];
            next_port_q <= next_port_q + 17'd1;
            mod_start_q <= 1'b1;
            mod_dvd_q   <= {16'd0, next_port_q[15:0]};
            mod_div_q   <= REV_M;
            mod_rec_q   <= REV_R;
            state_q     <= ST_MREV;
          end else begin
            act_q   <= npte_pkg::ACT_DROP;
            state_q <= ST_OUT;
          end
        end
        ST_MREV: begin
          if (mod_done) begin
            if (mode_q) begin
              rev_idx_q <= mod_rem[REV_W-1:0];
              state_q   <= ST_RRD;
            end else begin
              csum_start_q <= 1'b1;
              state_q      <= ST_CSUM;
            end
          end
        end
        ST_RRD: begin
          state_q <= ST_RCHK;
        end
        ST_RCHK: begin
          if (rev_rd_q.valid && rev_rd_q.proto == pr_q) begin
            act_q        <= npte_pkg::ACT_XLATE;
            nda_q        <= rev_rd_q.addr;
            ndp_q        <= rev_rd_q.port;
            csum_start_q <= 1'b1;
            state_q      <= ST_CSUM;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_CSUM: begin
          if (csum_done) begin
            nipc_q <= csum_out.ip;
            if (!l4_keep) begin
              nl4c_q <= l4_fix;
            end
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // checksum operands
  assign csum_in.ipc = ipc_q;
  assign csum_in.l4c = l4c_q;
  assign csum_in.sa  = sa_q;
  assign csum_in.nsa = nsa_q;
  assign csum_in.da  = da_q;
  assign csum_in.nda = nda_q;
  assign csum_in.sp  = sp_q;
  assign csum_in.nsp = nsp_q;
  assign csum_in.dp  = dp_q;
  assign csum_in.ndp = ndp_q;

  npte_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start_q),
    .sa_i    (sa_q),
    .da_i    (da_q),
    .sp_i    (sp_q),
    .dp_i    (dp_q),
    .pr_i    (pr_q),
    .done_o  (hash_done),
    .hash_o  (hash_val)
  );

  npte_mod #(
    .MOD_W (MOD_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start_q),
    .dividend_i (mod_dvd_q),
    .divisor_i  (mod_div_q),
    .recip_i    (mod_rec_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  npte_csum u_csum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (csum_start_q),
    .csum_i  (csum_in),
    .done_o  (csum_done),
    .csum_o  (csum_out)
  );

  // result port
  assign out_valid_o          = (state_q == ST_OUT);
  assign action_o             = act_q;
  assign new_source_address_o = nsa_q;
  assign new_dest_address_o   = nda_q;
  assign new_source_port_o    = nsp_q;
  assign new_dest_port_o      = ndp_q;
  assign ip_checksum_out_o    = nipc_q;
  assign l4_checksum_out_o    = nl4c_q;

endmodule

[hdl/npte_checker.sv]
// ----------------------------------------------------------------------------
// npte_checker
// port-level checks of the nat port translation engine, bound to the top level
// ----------------------------------------------------------------------------
`include "nat_port_translation_engine_defines.svh"

module npte_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] action_o
);

  // one item in flight: never ready while a result waits
  `NPTE_ASSERT(a_one_in_flight, !(in_ready_o && out_valid_o), "ready while result pending")

  // a held result stays offered
  `NPTE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")

  // a taken result is never shown twice
  `NPTE_ASSERT_NEXT(a_out_once, out_valid_o && out_ready_i, !out_valid_o, "result repeated")

  // action code is one of the defined ones
  `NPTE_ASSERT_IMPL(a_action_code, out_valid_o,
    action_o == npte_pkg::ACT_PASS || action_o == npte_pkg::ACT_XLATE ||
    action_o == npte_pkg::ACT_DROP, "bad action code")

endmodule

bind nat_port_translation_engine npte_checker u_npte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .action_o    (action_o)
);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// napt engine testbench
// drives parsed headers through the engine in phases of register settings,
// predicts each translation, drop or pass-through and checks every result
// field in order, with random idling on both sides and one long output stall
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned SETS      = npte_pkg::SESSION_ENTRIES_DEF /
                                      npte_pkg::SESSION_WAYS_DEF;
  localparam int unsigned WAYS      = npte_pkg::SESSION_WAYS_DEF;
  localparam int unsigned REV_SIZE  = npte_pkg::REVERSE_ENTRIES_DEF;
  localparam int unsigned LIMIT     = 800000;
  localparam int unsigned SETTLE    = 120;
  localparam int unsigned LONG_HOLD = 300;

  typedef struct packed {
    logic        mode;
    logic        v4;
    logic [7:0]  proto;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [15:0] ipc;
    logic [15:0] l4c;
  } hdr_t;

  typedef struct packed {
    npte_pkg::action_e act;
    logic [31:0] nsa;
    logic [31:0] nda;
    logic [15:0] nsp;
    logic [15:0] ndp;
    logic [15:0] ipc;
    logic [15:0] l4c;
  } xlat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  action_o;
  logic [31:0] new_source_address_o;
  logic [31:0] new_dest_address_o;
  logic [15:0] new_source_port_o;
  logic [15:0] new_dest_port_o;
  logic [15:0] ip_checksum_out_o;
  logic [15:0] l4_checksum_out_o;

  hdr_t  cur_hdr;
  hdr_t  hdr_q[$];
  xlat_t xlat_q[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned results_seen;
  logic  calm;

  // engine state as predicted
  npte_pkg::sess_entry_t sess_tab[int unsigned];
  npte_pkg::rev_entry_t  rev_tab[int unsigned];
  logic [31:0] wan_addr;
  logic [15:0] first_port;
  logic [15:0] end_port;
  logic [16:0] next_port;

  nat_port_translation_engine u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .mode_i(cur_hdr.mode), .is_ipv4_i(cur_hdr.v4), .protocol_i(cur_hdr.proto),
    .source_address_i(cur_hdr.sa), .dest_address_i(cur_hdr.da),
    .source_port_i(cur_hdr.sp), .dest_port_i(cur_hdr.dp),
    .ip_checksum_in_i(cur_hdr.ipc), .l4_checksum_in_i(cur_hdr.l4c),
    .out_valid_o, .out_ready_i, .action_o,
    .new_source_address_o, .new_dest_address_o,
    .new_source_port_o, .new_dest_port_o,
    .ip_checksum_out_o, .l4_checksum_out_o
  );

  // clock and reset, reset released on a falling edge
  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    forever begin
      #2 clk_i = ~clk_i;
      if (!clk_i && cycles == 3) rst_ni = 1'b1;
    end
  end

  // session set of a five-tuple
  function automatic int unsigned session_set(input hdr_t h);
    logic [31:0] x;
    x = (h.sa * npte_pkg::HASH_K1) ^ h.da;
    x ^= ({h.sp, h.dp} * npte_pkg::HASH_K2);
    x ^= {24'd0, h.proto};
    x ^= x >> 15;
    x = x * npte_pkg::HASH_K3;
    x ^= x >> 12;
    return x % SETS;
  endfunction

  // one's-complement word swap
  function automatic logic [31:0] swap_word(input logic [31:0] s, input logic [15:0] ow,
                                            input logic [15:0] nw);
    s = s + {16'd0, ~ow} + {16'd0, nw};
    s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    return s;
  endfunction

  function automatic logic [31:0] swap_addr(input logic [31:0] s, input logic [31:0] oa,
                                            input logic [31:0] na);
    s = swap_word(s, oa[31:16], na[31:16]);
    return swap_word(s, oa[15:0], na[15:0]);
  endfunction

  // incremental checksum patch, l4 without the udp zero remap
  function automatic npte_pkg::csum_out_t csum_patch(input hdr_t h, input logic [31:0] nsa,
                                                     input logic [31:0] nda,
                                                     input logic [15:0] nsp,
                                                     input logic [15:0] ndp);
    logic [31:0]         s;
    npte_pkg::csum_out_t c;
    s = swap_addr({16'd0, ~h.ipc}, h.sa, nsa);
    s = swap_addr(s, h.da, nda);
    c.ip = ~s[15:0];
    s = swap_addr({16'd0, ~h.l4c}, h.sa, nsa);
    s = swap_addr(s, h.da, nda);
    s = swap_word(s, h.sp, nsp);
    s = swap_word(s, h.dp, ndp);
    c.l4 = ~s[15:0];
    return c;
  endfunction

  // translation of one header, updating the tables
  task automatic translate(input hdr_t h, output xlat_t r);
    int                    hit;
    int                    free_way;
    int unsigned           base;
    logic [15:0]           wan;
    logic                  l4ok;
    npte_pkg::csum_out_t   c;
    npte_pkg::rev_entry_t  re;
    npte_pkg::sess_entry_t se;
    r = '{act: npte_pkg::ACT_PASS, nsa: h.sa, nda: h.da, nsp: h.sp, ndp: h.dp,
          ipc: h.ipc, l4c: h.l4c};
    l4ok = h.v4 && (h.proto == npte_pkg::PROTO_TCP || h.proto == npte_pkg::PROTO_UDP);
    hit = -1;
    free_way = -1;
    wan = '0;
    if (l4ok && !h.mode) begin
      base = session_set(h) * WAYS;
      for (int w = 0; w < WAYS; w++) begin
        if (sess_tab.exists(base + w)) begin
          se = sess_tab[base + w];
          if (hit < 0 && se.src == h.sa && se.dst == h.da && se.sport == h.sp &&
              se.dport == h.dp && se.proto == h.proto) hit = w;
        end else if (free_way < 0) begin
          free_way = w;
        end
      end
      if (hit >= 0) begin
        wan = sess_tab[base + hit].wan;
        r.act = npte_pkg::ACT_XLATE;
      end else if (free_way >= 0 && next_port < {1'b0, end_port}) begin
        wan = next_port[15:0];
        next_port = next_port + 17'd1;
        sess_tab[base + free_way] = '{valid: 1'b1, src: h.sa, dst: h.da, sport: h.sp,
                                      dport: h.dp, wan: wan, proto: h.proto};
        rev_tab[wan % REV_SIZE] = '{valid: 1'b1, proto: h.proto, addr: h.sa, port: h.sp};
        r.act = npte_pkg::ACT_XLATE;
      end else begin
        r.act = npte_pkg::ACT_DROP;
      end
      if (r.act == npte_pkg::ACT_XLATE) begin
        r.nsa = wan_addr;
        r.nsp = wan;
      end
    end else if (l4ok && h.mode && h.da == wan_addr && rev_tab.exists(h.dp % REV_SIZE)) begin
      re = rev_tab[h.dp % REV_SIZE];
      if (re.proto == h.proto) begin
        r.nda = re.addr;
        r.ndp = re.port;
        r.act = npte_pkg::ACT_XLATE;
      end
    end
    if (r.act == npte_pkg::ACT_XLATE) begin
      c = csum_patch(h, r.nsa, r.nda, r.nsp, r.ndp);
      r.ipc = c.ip;
      // udp without checksum stays zero, a zero result goes out as all ones
      if (!(h.proto == npte_pkg::PROTO_UDP && h.l4c == 16'd0)) begin
        r.l4c = (h.proto == npte_pkg::PROTO_UDP && c.l4 == 16'd0) ? 16'hFFFF : c.l4;
      end
    end
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("result %0d: %s got %h, want %h", results_seen, field, got, want);
    errors++;
  endtask

  // header driver
  int unsigned tx_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    xlat_t r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cur_hdr    <= '0;
      tx_gap     = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        translate(cur_hdr, r);
        xlat_q.push_back(r);
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (hdr_q.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
          tx_gap = $urandom_range(0, 3);
          in_valid_i <= 1'b0;
        end else if (hdr_q.size() != 0) begin
          cur_hdr    <= hdr_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int unsigned rx_gap;
  logic        long_done;
  always @(posedge clk_i or negedge rst_ni) begin
    xlat_t w;
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      rx_gap       = 0;
      long_done    = 1'b0;
      results_seen = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (xlat_q.size() == 0) begin
          $display("result %0d: no result expected", results_seen);
          errors++;
        end else begin
          w = xlat_q.pop_front();
          if (action_o != w.act) report("action", {30'd0, action_o}, {30'd0, w.act});
          if (new_source_address_o != w.nsa) report("src addr", new_source_address_o, w.nsa);
          if (new_dest_address_o != w.nda) report("dst addr", new_dest_address_o, w.nda);
          if (new_source_port_o != w.nsp) begin
            report("src port", {16'd0, new_source_port_o}, {16'd0, w.nsp});
          end
          if (new_dest_port_o != w.ndp) begin
            report("dst port", {16'd0, new_dest_port_o}, {16'd0, w.ndp});
          end
          if (ip_checksum_out_o != w.ipc) begin
            report("ip csum", {16'd0, ip_checksum_out_o}, {16'd0, w.ipc});
          end
          if (l4_checksum_out_o != w.l4c) begin
            report("l4 csum", {16'd0, l4_checksum_out_o}, {16'd0, w.l4c});
          end
        end
      end
      // one long hold-off so the engine backs up into its input
      if (!long_done && results_seen == 60) begin
        long_done = 1'b1;
        rx_gap    = LONG_HOLD;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        rx_gap = $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("nat_port_translation_engine: mismatch");
      $finish;
    end
  end

  // all three registers, engine idle
  task automatic write_regs(input logic [31:0] wan, input logic [15:0] fp,
                            input logic [15:0] ep);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= npte_pkg::CFG_WAN_ADDR;
    cfg_data_i <= wan;
    @(posedge clk_i);
    cfg_idx_i  <= npte_pkg::CFG_FIRST_PORT;
    cfg_data_i <= {16'd0, fp};
    @(posedge clk_i);
    cfg_idx_i  <= npte_pkg::CFG_END_PORT;
    cfg_data_i <= {16'd0, ep};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    wan_addr   = wan;
    first_port = fp;
    end_port   = ep;
    next_port  = {1'b0, fp};
  endtask

  // wait until every header is in and every result is out
  task automatic drain();
    while (hdr_q.size() != 0 || in_valid_i || xlat_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic hdr_t make_hdr(input logic mode, input logic [7:0] proto,
                                    input logic [31:0] sa, input logic [31:0] da,
                                    input logic [15:0] sp, input logic [15:0] dp);
    hdr_t h;
    h = '{mode: mode, v4: 1'b1, proto: proto, sa: sa, da: da, sp: sp, dp: dp,
          ipc: 16'($urandom_range(0, 65535)), l4c: 16'($urandom_range(1, 65535))};
    return h;
  endfunction

  function automatic hdr_t lan_tuple();
    return make_hdr(1'b0, $urandom_range(0, 1) ? npte_pkg::PROTO_TCP : npte_pkg::PROTO_UDP,
                    $urandom, $urandom, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)));
  endfunction

  // random traffic: new flows, flows from a small pool, return traffic, and noise
  task automatic random_traffic(input int unsigned n);
    hdr_t         pool[16];
    hdr_t         h;
    int unsigned  k;
    logic [159:0] noise;
    foreach (pool[i]) pool[i] = lan_tuple();
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 25) begin
        h = lan_tuple();
      end else if (k < 55) begin
        h = pool[$urandom_range(0, 15)];
        h.ipc = 16'($urandom_range(0, 65535));
        h.l4c = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
      end else if (k < 85) begin
        h = make_hdr(1'b1, $urandom_range(0, 1) ? npte_pkg::PROTO_TCP : npte_pkg::PROTO_UDP,
                     $urandom, ($urandom_range(0, 9) == 0) ? $urandom : wan_addr,
                     16'($urandom_range(0, 65535)),
                     16'(first_port + $urandom_range(0, 40)));
        if ($urandom_range(0, 9) == 0) h.l4c = 16'd0;
      end else begin
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
        h = noise[$bits(hdr_t)-1:0];
        if ($urandom_range(0, 1)) begin
          h.proto = $urandom_range(0, 1) ? npte_pkg::PROTO_TCP : npte_pkg::PROTO_UDP;
        end
      end
      hdr_q.push_back(h);
    end
  endtask

  initial begin
    hdr_t                h;
    hdr_t                crowd[$];
    npte_pkg::csum_out_t c;
    int unsigned         target;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = npte_pkg::CFG_WAN_ADDR;
    cfg_data_i = '0;
    calm       = 1'b0;
    wan_addr   = npte_pkg::WAN_ADDR_RST;
    first_port = npte_pkg::FIRST_PORT_RST;
    end_port   = npte_pkg::END_PORT_RST;
    next_port  = {1'b0, npte_pkg::FIRST_PORT_RST};
    // reset and the table clearing pass
    while (in_ready_o !== 1'b1) @(posedge clk_i);

    // directed: translations, hits, return traffic and pass-through cases
    write_regs(32'hCB00_7101, 16'd10000, 16'd60000);
    h = make_hdr(1'b0, npte_pkg::PROTO_UDP, 32'h0A00_0005, 32'h0808_0808, 16'd5353, 16'd53);
    // udp checksum that patches to zero and goes out as all ones
    for (int v = 1; v < 65536; v++) begin
      h.l4c = v[15:0];
      c = csum_patch(h, wan_addr, h.da, 16'd10000, h.dp);
      if (c.l4 == 16'd0) break;
    end
    hdr_q.push_back(h);
    h = make_hdr(1'b0, npte_pkg::PROTO_UDP, 32'h0A00_0006, 32'h0101_0101, 16'd40000, 16'd123);
    h.l4c = 16'd0;
    hdr_q.push_back(h);
    h = make_hdr(1'b0, npte_pkg::PROTO_TCP, 32'h0A00_0007, 32'h0102_0304, 16'd51000, 16'd443);
    hdr_q.push_back(h);
    hdr_q.push_back(h);
    hdr_q.push_back('0);
    hdr_q.push_back('1);
    h.v4 = 1'b0;
    hdr_q.push_back(h);
    h.v4 = 1'b1;
    h.proto = 8'd1;
    hdr_q.push_back(h);
    hdr_q.push_back(make_hdr(1'b1, npte_pkg::PROTO_UDP, 32'h0808_0808, wan_addr,
                             16'd53, 16'd10000));
    hdr_q.push_back(make_hdr(1'b1, npte_pkg::PROTO_TCP, 32'h0808_0808, wan_addr,
                             16'd53, 16'd10000));
    hdr_q.push_back(make_hdr(1'b1, npte_pkg::PROTO_UDP, 32'h0808_0808, 32'h0A00_0001,
                             16'd53, 16'd10000));
    hdr_q.push_back(make_hdr(1'b1, npte_pkg::PROTO_TCP, 32'h0102_0304, wan_addr,
                             16'd443, 16'd10002));
    hdr_q.push_back(make_hdr(1'b0, npte_pkg::PROTO_TCP, 32'h0, 32'hFFFF_FFFF,
                             16'h0, 16'hFFFF));
    hdr_q.push_back(make_hdr(1'b1, npte_pkg::PROTO_TCP, 32'hFFFF_FFFF, wan_addr,
                             16'hFFFF, 16'hFFFF));
    // five flows in one session set: the fifth finds no free way
    h = lan_tuple();
    target = session_set(h);
    crowd.push_back(h);
    for (int v = 0; crowd.size() < 5; v++) begin
      h.sp = v[15:0];
      h.dp = v[31:16];
      if (session_set(h) == target) crowd.push_back(h);
    end
    foreach (crowd[i]) hdr_q.push_back(crowd[i]);
    hdr_q.push_back(lan_tuple());
    hdr_q.push_back(crowd[1]);
    drain();

    // pool of one port, then none at all
    write_regs(32'hFFFF_FFFF, 16'd65534, 16'd65535);
    repeat (3) hdr_q.push_back(lan_tuple());
    hdr_q.push_back(make_hdr(1'b1, npte_pkg::PROTO_TCP, 32'h0505_0505, 32'hFFFF_FFFF,
                             16'd80, 16'd65534));
    hdr_q.push_back(make_hdr(1'b1, npte_pkg::PROTO_UDP, 32'h0505_0505, 32'hFFFF_FFFF,
                             16'd80, 16'd65534));
    drain();
    write_regs(32'h0, 16'd65535, 16'd65535);
    repeat (2) hdr_q.push_back(lan_tuple());
    drain();
    write_regs(32'h0, 16'd0, 16'd0);
    repeat (2) hdr_q.push_back(lan_tuple());
    drain();
    // reloading the first port reuses ports and overwrites reverse entries
    write_regs(32'h6440_0001, 16'd0, 16'd3);
    repeat (4) hdr_q.push_back(lan_tuple());
    drain();
    write_regs(32'h6440_0001, 16'd0, 16'd2);
    repeat (2) hdr_q.push_back(lan_tuple());
    hdr_q.push_back(make_hdr(1'b1, npte_pkg::PROTO_TCP, 32'h0909_0909, wan_addr,
                             16'd22, 16'd0));
    hdr_q.push_back(make_hdr(1'b1, npte_pkg::PROTO_UDP, 32'h0909_0909, wan_addr,
                             16'd22, 16'd1));
    drain();

    // random phases
    write_regs($urandom, 16'd1000, 16'd60000);
    random_traffic(220);
    drain();
    write_regs($urandom, 16'd0, 16'd65535);
    random_traffic(160);
    drain();
    calm = 1'b1;
    write_regs($urandom, 16'd65500, 16'd65530);
    random_traffic(120);
    drain();

    if (errors == 0) begin
      $display("nat_port_translation_engine: match");
    end else begin
      $display("nat_port_translation_engine: mismatch");
    end
    $finish;
  end

endmodule
